@@ sv/sccbw_pkg.sv @@
// Shared types and constants for the SCCB write master.
// Used by sccbw_front, sccbw_back and sccb_write_master_top; depends on nothing.
package sccbw_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam logic [3:0] ACK_SLOT = 4'(BYTE_BITS);
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd375;

  // Phase numbers inside a segment.
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD = 2'd2;
  localparam logic [1:0] PH_FOURTH = 2'd3;

  typedef enum logic [3:0] {
    SEG_IDLE  = 4'b0001,
    SEG_START = 4'b0010,
    SEG_BITS  = 4'b0100,
    SEG_STOP  = 4'b1000
  } seg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stop_after;
    seg_t       first_seg;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

@@ sv/sccb_write_master_top.sv @@
// Write-only open-drain SCCB master. Each accepted byte produces a sequence
// of held line states on the output channel, one per transaction: four for an
// optional start condition, three per data bit MSB first, three for the
// acknowledge slot (never sampled) and three for an optional stop condition.
// Each line state is presented once the previous one has been held for the
// length programmed in phase_ticks, timed by a single hold counter in the back
// end; a stalled output channel delays the next line state further.
// A two-entry queue lets the next bytes be accepted while one is being sent.
// Writing 0 to phase_ticks is taken as 1. The user must write the register
// only while the block is idle; the block itself does not enforce this.
// Depends on sccbw_pkg, sccbw_front and sccbw_back.
module sccb_write_master_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_before,
  input  logic        stop_after,
  output logic        phase_valid,
  input  logic        phase_stall,
  output logic        sda_pull_low,
  output logic        scl_pull_low,
  output logic        last_phase
);

  sccbw_pkg::q_head_t head;
  logic pop;

  assign cfg_ready = 1'b1;

  sccbw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .start_before (start_before),
    .stop_after   (stop_after),
    .head         (head),
    .pop          (pop)
  );

  sccbw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .head         (head),
    .pop          (pop),
    .phase_valid  (phase_valid),
    .phase_stall  (phase_stall),
    .sda_pull_low (sda_pull_low),
    .scl_pull_low (scl_pull_low),
    .last_phase   (last_phase)
  );

endmodule

@@ sv/sccbw_front.sv @@
// Front end of the SCCB write master: accepts bytes, classifies them into
// commands and buffers them in a two-entry queue. Depends on sccbw_pkg.
module sccbw_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [7:0]         data_byte,
  input  logic               start_before,
  input  logic               stop_after,
  output sccbw_pkg::q_head_t head,
  input  logic               pop
);

  sccbw_pkg::cmd_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       do_pop;
  sccbw_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.data_byte  = data_byte;
    cmd_in.stop_after = stop_after;
    cmd_in.first_seg  = start_before ? sccbw_pkg::SEG_START : sccbw_pkg::SEG_BITS;
  end

  assign byte_stall = (count == 2'd2);
  assign push       = byte_valid && !byte_stall;
  assign do_pop     = pop && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("command taken from an empty queue");

  a_ptrs_agree: assert property (@(posedge clk) disable iff (rst)
    ((count == 2'd0) || (count == 2'd2)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with the fill count");

endmodule

@@ sv/sccbw_back.sv @@
// Back end of the SCCB write master: sequences start, data, acknowledge and
// stop phases and holds each line state for the length programmed in phase_ticks. Depends on sccbw_pkg.
module sccbw_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  input  sccbw_pkg::q_head_t head,
  output logic               pop,
  output logic               phase_valid,
  input  logic               phase_stall,
  output logic               sda_pull_low,
  output logic               scl_pull_low,
  output logic               last_phase
);

  sccbw_pkg::seg_t seg;
  logic [1:0]  phase;
  logic [3:0]  bit_idx;
  logic [7:0]  shift;
  logic        stop_pending;
  logic        scl_state;
  logic [15:0] hold;
  logic [15:0] phase_ticks;

  logic e_sda;
  logic e_scl;
  logic e_last;
  logic emit;
  logic load;

  always_comb begin
    e_sda  = 1'b0;
    e_scl  = 1'b0;
    e_last = 1'b0;
    unique case (seg)
      sccbw_pkg::SEG_START: begin
        if (phase == sccbw_pkg::PH_FIRST) begin
          e_sda = 1'b0;
          e_scl = scl_state;
        end else if (phase == sccbw_pkg::PH_SECOND) begin
          e_sda = 1'b0;
          e_scl = 1'b0;
        end else if (phase == sccbw_pkg::PH_THIRD) begin
          e_sda = 1'b1;
          e_scl = 1'b0;
        end else begin
          e_sda = 1'b1;
          e_scl = 1'b1;
        end
      end
      sccbw_pkg::SEG_BITS: begin
        // The acknowledge slot releases the data wire.
        e_sda = (bit_idx == sccbw_pkg::ACK_SLOT) ? 1'b0 : ~shift[7];
        if (phase == sccbw_pkg::PH_FIRST) begin
          e_scl = scl_state;
        end else if (phase == sccbw_pkg::PH_SECOND) begin
          e_scl = 1'b0;
        end else begin
          e_scl = 1'b1;
        end
        e_last = (phase == sccbw_pkg::PH_THIRD) && (bit_idx == sccbw_pkg::ACK_SLOT)
                 && !stop_pending;
      end
      sccbw_pkg::SEG_STOP: begin
        if (phase == sccbw_pkg::PH_FIRST) begin
          e_sda = 1'b1;
          e_scl = scl_state;
        end else if (phase == sccbw_pkg::PH_SECOND) begin
          e_sda = 1'b1;
          e_scl = 1'b0;
        end else begin
          e_sda = 1'b0;
          e_scl = 1'b0;
        end
        e_last = (phase == sccbw_pkg::PH_THIRD);
      end
      default: begin
        e_sda  = 1'b0;
        e_scl  = 1'b0;
        e_last = 1'b0;
      end
    endcase
  end

  // A new phase goes out once the previous one has been held long enough
  // and the output register is free or being emptied this cycle.
  assign emit = (seg != sccbw_pkg::SEG_IDLE) && (hold == 16'd0)
                && (!phase_valid || !phase_stall);
  assign load = head.valid && ((seg == sccbw_pkg::SEG_IDLE) || (emit && e_last));
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (emit) begin
      sda_pull_low <= e_sda;
      scl_pull_low <= e_scl;
      last_phase   <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shift        <= head.cmd.data_byte;
      stop_pending <= head.cmd.stop_after;
    end else if (emit && (seg == sccbw_pkg::SEG_BITS) && (phase == sccbw_pkg::PH_THIRD)) begin
      shift <= {shift[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg         <= sccbw_pkg::SEG_IDLE;
      phase       <= sccbw_pkg::PH_FIRST;
      bit_idx     <= 4'd0;
      scl_state   <= 1'b0;
      hold        <= 16'd0;
      phase_valid <= 1'b0;
      phase_ticks <= sccbw_pkg::PHASE_TICKS_RESET;
    end else begin
      if (cfg_write) begin
        phase_ticks <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
      end

      if (emit) begin
        phase_valid <= 1'b1;
        scl_state   <= e_scl;
        hold        <= phase_ticks - 16'd1;
      end else begin
        if (phase_valid && !phase_stall) begin
          phase_valid <= 1'b0;
        end
        if (hold != 16'd0) begin
          hold <= hold - 16'd1;
        end
      end

      if (load) begin
        seg     <= head.cmd.first_seg;
        phase   <= sccbw_pkg::PH_FIRST;
        bit_idx <= 4'd0;
      end else if (emit) begin
        if (e_last) begin
          seg     <= sccbw_pkg::SEG_IDLE;
          phase   <= sccbw_pkg::PH_FIRST;
          bit_idx <= 4'd0;
        end else begin
          unique case (seg)
            sccbw_pkg::SEG_START: begin
              if (phase == sccbw_pkg::PH_FOURTH) begin
                seg     <= sccbw_pkg::SEG_BITS;
                phase   <= sccbw_pkg::PH_FIRST;
                bit_idx <= 4'd0;
              end else begin
                phase <= phase + 2'd1;
              end
            end
            sccbw_pkg::SEG_BITS: begin
              if (phase == sccbw_pkg::PH_THIRD) begin
                phase <= sccbw_pkg::PH_FIRST;
                if (bit_idx == sccbw_pkg::ACK_SLOT) begin
                  seg     <= sccbw_pkg::SEG_STOP;
                  bit_idx <= 4'd0;
                end else begin
                  bit_idx <= bit_idx + 4'd1;
                end
              end else begin
                phase <= phase + 2'd1;
              end
            end
            sccbw_pkg::SEG_STOP: begin
              phase <= phase + 2'd1;
            end
            default: begin
              seg <= sccbw_pkg::SEG_IDLE;
            end
          endcase
        end
      end
    end
  end

  a_scl_tracks: assert property (@(posedge clk) disable iff (rst)
    phase_valid |-> (scl_pull_low == scl_state))
    else $error("clock wire output disagrees with tracked clock state");

  a_hold_bound: assert property (@(posedge clk) disable iff (rst)
    hold < phase_ticks)
    else $error("hold counter exceeds programmed phase length");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (seg == sccbw_pkg::SEG_IDLE) |-> (phase == sccbw_pkg::PH_FIRST) && (bit_idx == 4'd0))
    else $error("sequencer idle with stale counters");

  a_start_not_last: assert property (@(posedge clk) disable iff (rst)
    (emit && (seg == sccbw_pkg::SEG_START)) |-> !e_last)
    else $error("start condition marked as final phase");

  a_pop_on_end: assert property (@(posedge clk) disable iff (rst)
    (pop && (seg != sccbw_pkg::SEG_IDLE)) |-> (emit && e_last))
    else $error("command loaded while a byte is still in progress");

endmodule

@@ tb/sv/tb_sccb_write_master_top.sv @@
// Self-checking testbench for sccb_write_master_top: bytes with random start and stop
// flags go in, every held line state that comes out is checked against a line-state predictor.
// Depends on sccbw_pkg and the block's RTL.
module tb_sccb_write_master_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 300000;
  localparam int unsigned MAX_GAP = 18;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       stop;
  } byte_cmd_t;

  typedef struct packed {
    logic sda;
    logic scl;
    logic last;
  } line_state_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  data_byte = '0;
  logic        start_before = 1'b0;
  logic        stop_after = 1'b0;
  logic        phase_valid;
  logic        phase_stall = 1'b0;
  logic        sda_pull_low;
  logic        scl_pull_low;
  logic        last_phase;

  byte_cmd_t   pending_bytes[$];
  line_state_t line_state_q[$];
  byte_cmd_t   cur_cmd;

  // Predicted wire drive, updated as line states are predicted.
  logic        sda_model;
  logic        scl_model;
  int          phases_left;
  int unsigned hold_ticks = sccbw_pkg::PHASE_TICKS_RESET;

  int unsigned queued_bytes = 0;
  int unsigned accepted_bytes = 0;
  int unsigned fault_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  bit          no_gaps = 1'b0;

  sccb_write_master_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .data_byte   (data_byte),
    .start_before(start_before),
    .stop_after  (stop_after),
    .phase_valid (phase_valid),
    .phase_stall (phase_stall),
    .sda_pull_low(sda_pull_low),
    .scl_pull_low(scl_pull_low),
    .last_phase  (last_phase)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic put_line(input logic sda, input logic scl);
    line_state_t s;
    sda_model = sda;
    scl_model = scl;
    phases_left--;
    s.sda = sda;
    s.scl = scl;
    s.last = (phases_left == 0);
    line_state_q.push_back(s);
  endtask

  // One byte: optional start, eight bits MSB first, the unsampled acknowledge
  // slot, optional stop. A bit phase first keeps whatever clock drive is held.
  task automatic predict_line_states(input byte_cmd_t c);
    phases_left = 3 * (sccbw_pkg::BYTE_BITS + 1) + (c.start ? 4 : 0) + (c.stop ? 3 : 0);
    if (c.start) begin
      put_line(1'b0, scl_model);
      put_line(1'b0, 1'b0);
      put_line(1'b1, 1'b0);
      put_line(1'b1, 1'b1);
    end
    for (int k = sccbw_pkg::BYTE_BITS - 1; k >= 0; k--) begin
      put_line(!c.data[k], scl_model);
      put_line(!c.data[k], 1'b0);
      put_line(!c.data[k], 1'b1);
    end
    put_line(1'b0, scl_model);
    put_line(1'b0, 1'b0);
    put_line(1'b0, 1'b1);
    if (c.stop) begin
      put_line(1'b1, scl_model);
      put_line(1'b1, 1'b0);
      put_line(1'b0, 1'b0);
    end
  endtask

  always @(posedge clk) begin : byte_driver
    byte_cmd_t   nxt;
    int unsigned gap;
    if (rst) begin
      byte_valid <= 1'b0;
      gap_left <= 0;
      sda_model = 1'b0;
      scl_model = 1'b0;
    end else if (byte_valid && !byte_stall) begin
      predict_line_states(cur_cmd);
      accepted_bytes <= accepted_bytes + 1;
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap == 0 && pending_bytes.size() != 0) begin
        nxt = pending_bytes.pop_front();
        cur_cmd <= nxt;
        data_byte <= nxt.data;
        start_before <= nxt.start;
        stop_after <= nxt.stop;
        byte_valid <= 1'b1;
      end else begin
        byte_valid <= 1'b0;
        gap_left <= gap;
      end
    end else if (!byte_valid) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_bytes.size() != 0) begin
        nxt = pending_bytes.pop_front();
        cur_cmd <= nxt;
        data_byte <= nxt.data;
        start_before <= nxt.start;
        stop_after <= nxt.stop;
        byte_valid <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : line_monitor
    line_state_t exp_s;
    int unsigned hold;
    if (rst) begin
      phase_stall <= 1'b0;
      stall_left <= 0;
    end else if (phase_valid && !phase_stall) begin
      if (line_state_q.size() == 0) begin
        if (fault_count < REPORT_LIMIT)
          $display("unexpected line state sda=%0b scl=%0b last=%0b",
                   sda_pull_low, scl_pull_low, last_phase);
        fault_count <= fault_count + 1;
      end else begin
        exp_s = line_state_q.pop_front();
        if (sda_pull_low !== exp_s.sda || scl_pull_low !== exp_s.scl ||
            last_phase !== exp_s.last) begin
          if (fault_count < REPORT_LIMIT)
            $display("line state mismatch: expected sda=%0b scl=%0b last=%0b, got %0b %0b %0b",
                     exp_s.sda, exp_s.scl, exp_s.last,
                     sda_pull_low, scl_pull_low, last_phase);
          fault_count <= fault_count + 1;
        end
      end
      hold = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      stall_left <= hold;
      phase_stall <= (hold != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      phase_stall <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (phase_valid && !phase_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] d, input logic s, input logic p);
    byte_cmd_t c;
    c.data = d;
    c.start = s;
    c.stop = p;
    pending_bytes.push_back(c);
    queued_bytes++;
  endtask

  // Mostly complete writes (start, address, up to three data bytes, stop) with
  // random content; the rest are bytes with random start and stop flags.
  task automatic queue_random_bytes(input int unsigned count);
    int unsigned made;
    int unsigned body;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 3) != 0) begin
        body = $urandom_range(0, 3);
        queue_byte(8'($urandom), 1'b1, body == 0);
        made++;
        for (int unsigned j = 1; j <= body; j++) begin
          queue_byte(8'($urandom), 1'b0, j == body);
          made++;
        end
      end else begin
        queue_byte(8'($urandom), 1'($urandom), 1'($urandom));
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (accepted_bytes != queued_bytes || line_state_q.size() != 0);
  endtask

  // The last line state is still held after it is accepted, so let it run out
  // before touching the register.
  task automatic set_phase_ticks(input logic [15:0] value);
    wait_drained();
    repeat (hold_ticks + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    hold_ticks = (value == 0) ? 1 : value;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // A short write at the reset hold time.
    queue_byte(8'h42, 1'b1, 1'b0);
    queue_byte(8'h1A, 1'b0, 1'b0);
    queue_byte(8'h80, 1'b0, 1'b1);

    // A zero hold-time setting is taken as 1.
    set_phase_ticks(16'd0);
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'hAA, 1'b0, 1'b1);
    // Byte with no open transfer, sent from the released bus.
    queue_byte(8'h55, 1'b0, 1'b0);
    queue_byte(8'h80, 1'b1, 1'b1);
    // Repeated start while the clock is held low.
    queue_byte(8'h01, 1'b1, 1'b0);
    queue_byte(8'h7F, 1'b1, 1'b0);
    queue_byte(8'hFE, 1'b0, 1'b1);
    queue_byte(8'h0F, 1'b0, 1'b1);
    queue_byte(8'hF0, 1'b1, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b0);

    set_phase_ticks(16'd1);
    no_gaps = 1'b1;
    queue_random_bytes(30);

    set_phase_ticks(16'd2);
    no_gaps = 1'b0;
    queue_random_bytes(30);

    set_phase_ticks(16'hFFFF);
    queue_byte(8'($urandom), 1'b0, 1'b0);

    set_phase_ticks(16'($urandom_range(3, 9)));
    queue_random_bytes(30);

    wait_drained();
    repeat (2 * hold_ticks + 20) @(posedge clk);
    if (line_state_q.size() != 0) begin
      $display("%0d line states never arrived", line_state_q.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
